### sv/bmu_pkg.sv
// ----------------------------------------------------------------------------
// bmu_pkg
// Shared types and constants of the breakpoint match unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bmu_pkg;

  localparam int NumEntries = 16;
  localparam int CmdW       = 2;
  localparam int SlotW      = 4;
  localparam int KindW      = 2;
  localparam int TargetW    = 16;
  localparam int PIdxW      = 4;
  localparam int OpcodeW    = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_CHECK = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_OFF  = 2'd0,
    KIND_ADDR = 2'd1,
    KIND_PIDX = 2'd2,
    KIND_OPC  = 2'd3
  } kind_e;

  typedef struct packed {
    logic capture;
    logic check;
    logic set_entry;
    logic clear_entry;
  } dp_cmd_t;

endpackage

`default_nettype wire

### sv/bmu_ctrl.sv
// ----------------------------------------------------------------------------
// bmu_ctrl
// Handshake controller: decodes accepted transactions into datapath commands
// and tracks the occupancy of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmu_ctrl
  import bmu_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [CmdW-1:0] command_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output dp_cmd_t              dp_cmd_o
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_EMPTY) || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    dp_cmd_o.capture     = accept;
    dp_cmd_o.check       = 1'b0;
    dp_cmd_o.set_entry   = 1'b0;
    dp_cmd_o.clear_entry = 1'b0;
    case (cmd_e'(command_i))
      CMD_CHECK: dp_cmd_o.check       = accept;
      CMD_SET:   dp_cmd_o.set_entry   = accept;
      CMD_CLEAR: dp_cmd_o.clear_entry = accept;
      default:   dp_cmd_o.check       = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_EMPTY: begin
        if (accept) begin
          state_d = ST_FULL;
        end
      end
      ST_FULL: begin
        if (out_ready_i && !accept) begin
          state_d = ST_EMPTY;
        end
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EMPTY;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_o <= (state_d == ST_FULL);
    end
  end

endmodule

`default_nettype wire

### sv/bmu_dp.sv
// ----------------------------------------------------------------------------
// bmu_dp
// Datapath: breakpoint entry registers, parallel match logic and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmu_dp
  import bmu_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            dp_cmd_i,
  input  wire logic [SlotW-1:0]   slot_i,
  input  wire logic [KindW-1:0]   kind_i,
  input  wire logic [TargetW-1:0] target_i,
  input  wire logic [TargetW-1:0] pc_value_i,
  input  wire logic [PIdxW-1:0]   p_index_i,
  input  wire logic [OpcodeW-1:0] opcode_i,
  input  wire logic               step_mode_i,
  input  wire logic               halt_request_i,
  output logic                    enter_monitor_o
);

  kind_e              kind_q   [NumEntries];
  logic [TargetW-1:0] target_q [NumEntries];
  logic [NumEntries-1:0] hit;
  logic [TargetW-1:0]    masked_target;
  logic                  enter_d;

  always_comb begin
    case (kind_e'(kind_i))
      KIND_ADDR: masked_target = target_i;
      KIND_PIDX: masked_target = {{(TargetW-PIdxW){1'b0}}, target_i[PIdxW-1:0]};
      KIND_OPC:  masked_target = {{(TargetW-OpcodeW){1'b0}}, target_i[OpcodeW-1:0]};
      default:   masked_target = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NumEntries; i++) begin
      case (kind_q[i])
        KIND_ADDR: hit[i] = (target_q[i] == pc_value_i);
        KIND_PIDX: hit[i] = (target_q[i] == {{(TargetW-PIdxW){1'b0}}, p_index_i});
        KIND_OPC:  hit[i] = (target_q[i] == {{(TargetW-OpcodeW){1'b0}}, opcode_i});
        default:   hit[i] = 1'b0;
      endcase
    end
  end

  assign enter_d = dp_cmd_i.check && (halt_request_i || (!step_mode_i && (|hit)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumEntries; i++) begin
        kind_q[i]   <= KIND_OFF;
        target_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NumEntries; i++) begin
        if (int'(slot_i) == i) begin
          if (dp_cmd_i.set_entry) begin
            kind_q[i]   <= kind_e'(kind_i);
            target_q[i] <= masked_target;
          end else if (dp_cmd_i.clear_entry) begin
            kind_q[i] <= KIND_OFF;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      enter_monitor_o <= enter_d;
    end
  end

endmodule

`default_nettype wire

### sv/breakpoint_match_unit.sv
// ----------------------------------------------------------------------------
// breakpoint_match_unit
// Debug breakpoint comparator with set, clear and check transactions.
// ----------------------------------------------------------------------------
// Every transaction yields one result: a check returns enter_monitor, a set
// or clear returns 0. All breakpoint entries are held in flip-flops and
// compared in parallel, so a new transaction is taken every cycle while the
// result register is empty or being drained; the single result register
// places each result in the cycle after its transaction is accepted.
`default_nettype none

module breakpoint_match_unit
  import bmu_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [CmdW-1:0]    command_i,
  input  wire logic [SlotW-1:0]   slot_i,
  input  wire logic [KindW-1:0]   kind_i,
  input  wire logic [TargetW-1:0] target_i,
  input  wire logic [TargetW-1:0] pc_value_i,
  input  wire logic [PIdxW-1:0]   p_index_i,
  input  wire logic [OpcodeW-1:0] opcode_i,
  input  wire logic               step_mode_i,
  input  wire logic               halt_request_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    enter_monitor_o
);

  dp_cmd_t dp_cmd;

  bmu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd)
  );

  bmu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dp_cmd_i        (dp_cmd),
    .slot_i          (slot_i),
    .kind_i          (kind_i),
    .target_i        (target_i),
    .pc_value_i      (pc_value_i),
    .p_index_i       (p_index_i),
    .opcode_i        (opcode_i),
    .step_mode_i     (step_mode_i),
    .halt_request_i  (halt_request_i),
    .enter_monitor_o (enter_monitor_o)
  );

endmodule

`default_nettype wire
